FILE: src/ax25f_pkg.sv
// Shared types, constants and helper functions for the AX.25 address filter
// and IPv4/UDP header rebuild block. No dependencies.
`default_nettype none

package ax25f_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned LenW          = 11;
  localparam int unsigned CharW         = 7;
  localparam int unsigned NumChars      = 6;
  localparam int unsigned CallW         = CharW * NumChars;
  localparam int unsigned SsidW         = 4;
  localparam int unsigned ModeW         = 2;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = CallW;
  localparam int unsigned HdrBytes      = 28;
  localparam int unsigned HdrIdxW       = $clog2(HdrBytes);

  localparam logic [7:0]       IpMarker  = 8'h46;
  localparam logic [CharW-1:0] CharSpace = 7'h20;
  localparam logic [CharW-1:0] CharNul   = 7'h00;

  // Frame byte positions
  localparam logic [LenW-1:0] PosMax       = '1;
  localparam logic [LenW-1:0] DestLastChar = LenW'(5);
  localparam logic [LenW-1:0] DestSsidPos  = LenW'(6);
  localparam logic [LenW-1:0] SrcFirstPos  = LenW'(7);
  localparam logic [LenW-1:0] SrcLastChar  = LenW'(12);
  localparam logic [LenW-1:0] SrcSsidPos   = LenW'(13);
  localparam logic [LenW-1:0] FirstDataPos = LenW'(16);
  localparam logic [LenW-1:0] MinLen       = LenW'(17);

  // Rebuilt header: fixed bytes and the places of the computed fields
  localparam logic [7:0] HdrTemplate [HdrBytes] = '{
    8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00,
    8'h40, 8'h11, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h02, 8'h8b, 8'hc1, 8'h8b, 8'hc1,
    8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [HdrIdxW-1:0] HdrTlHi   = HdrIdxW'(2);
  localparam logic [HdrIdxW-1:0] HdrTlLo   = HdrIdxW'(3);
  localparam logic [HdrIdxW-1:0] HdrCsHi   = HdrIdxW'(10);
  localparam logic [HdrIdxW-1:0] HdrCsLo   = HdrIdxW'(11);
  localparam logic [HdrIdxW-1:0] HdrUlHi   = HdrIdxW'(24);
  localparam logic [HdrIdxW-1:0] HdrUlLo   = HdrIdxW'(25);
  localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrBytes - 1);

  localparam logic [15:0] TlOffset = 16'd11;
  localparam logic [15:0] UlOffset = 16'd17;
  // Ones' complement sum of the fixed header words (start value 0xffff folds away)
  localparam logic [15:0] CsBase   = 16'hC916;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_MODE = 3'd0,
    CFG_DEST_CALL   = 3'd1,
    CFG_DEST_SSID   = 3'd2,
    CFG_SRC_CALL    = 3'd3,
    CFG_SRC_SSID    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BYTE,
    KIND_HDR
  } out_kind_e;

  typedef struct packed {
    logic [ModeW-1:0] filter_mode;
    logic [CallW-1:0] dest_callsign;
    logic [SsidW-1:0] dest_ssid;
    logic [CallW-1:0] src_callsign;
    logic [SsidW-1:0] src_ssid;
  } cfg_t;

  typedef struct packed {
    out_kind_e       kind;
    logic            last;
    logic [LenW-1:0] held_len;
  } filt_res_t;

  function automatic logic ends_call(input logic [CharW-1:0] c);
    return (c == CharSpace) || (c == CharNul);
  endfunction

  function automatic logic [CharW-1:0] reg_char(input logic [CallW-1:0] call,
                                                input logic [2:0] idx);
    logic [CharW-1:0] c;
    c = '0;
    for (int i = 0; i < NumChars; i++) begin
      if (3'(i) == idx) begin
        c = call[CallW-1-CharW*i -: CharW];
      end
    end
    return c;
  endfunction

  // Character idx of the frame callsign agrees with the configured one,
  // both strings being cut at the first space or NUL.
  function automatic logic char_agrees(input logic [CallW-1:0] call,
                                       input logic [2:0] idx,
                                       input logic [CharW-1:0] fc,
                                       input logic seen);
    logic reg_done;
    logic frame_done;
    reg_done = 1'b0;
    for (int i = 0; i < NumChars; i++) begin
      if ((3'(i) <= idx) && ends_call(call[CallW-1-CharW*i -: CharW])) begin
        reg_done = 1'b1;
      end
    end
    frame_done = seen || ends_call(fc);
    if (reg_done || frame_done) begin
      return reg_done && frame_done;
    end
    return fc == reg_char(call, idx);
  endfunction

endpackage

`default_nettype wire

FILE: src/ax25_filter_ip_header_rebuild.sv
// An accepted input transaction passes through one input register, then one
// output register, before its output byte is valid.
// The block takes one byte per cycle unless the output stalls; a marker byte
// at position 16 expands into a 28-byte header burst, during which the input
// stalls. Bytes of dropped or short frames and filler bytes past the length
// produce nothing and retire even while the output is stalled, unless a header
// burst is running. Reset (rst_ni low, asynchronous) clears all control state
// and the configuration registers, but not the byte payload registers.
`default_nettype none

module ax25_filter_ip_header_rebuild import ax25f_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // frame byte input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  input  logic [LenW-1:0]     frame_length_i,
  // packet byte output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  // Configuration registers: always ready; user must write only while idle, not enforced
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FILTER_MODE: cfg_q.filter_mode   <= cfg_data_i[ModeW-1:0];
        CFG_DEST_CALL:   cfg_q.dest_callsign <= cfg_data_i[CallW-1:0];
        CFG_DEST_SSID:   cfg_q.dest_ssid     <= cfg_data_i[SsidW-1:0];
        CFG_SRC_CALL:    cfg_q.src_callsign  <= cfg_data_i[CallW-1:0];
        CFG_SRC_SSID:    cfg_q.src_ssid      <= cfg_data_i[SsidW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: holds one transaction until the filter retires it
  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_end_q;
  logic [LenW-1:0] s1_len_q;
  logic            s1_go;
  logic            out_free;

  filt_res_t       filt_res;

  // Header burst state
  logic               hdr_active_q, hdr_active_d;
  logic [HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic               hdr_last_q, hdr_last_d;
  logic [HdrIdxW-1:0] hdr_sel;
  logic [7:0]         hdr_byte;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  assign out_free = !out_valid_q || out_ready_i;
  // Retire the held byte unless a burst is running or its result cannot land
  assign s1_go = s1_valid_q && !hdr_active_q && ((filt_res.kind == KIND_NONE) || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_end_q  <= frame_end_i;
      s1_len_q  <= frame_length_i;
    end
  end

  ax25f_filter u_filter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (s1_go),
    .data_byte_i    (s1_byte_q),
    .frame_end_i    (s1_end_q),
    .frame_length_i (s1_len_q),
    .cfg_i          (cfg_q),
    .res_o          (filt_res)
  );

  // Header byte 0 is fetched when the burst starts, later ones from the counter
  assign hdr_sel = hdr_active_q ? hdr_idx_q : '0;

  ax25f_hdr u_hdr (
    .idx_i      (hdr_sel),
    .held_len_i (filt_res.held_len),
    .byte_o     (hdr_byte)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    hdr_active_d = hdr_active_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_last_d   = hdr_last_q;
    if (hdr_active_q && out_free) begin
      // advance the burst by one header byte
      out_valid_d = 1'b1;
      out_byte_d  = hdr_byte;
      out_last_d  = (hdr_idx_q == HdrLastIdx) && hdr_last_q;
      hdr_idx_d   = hdr_idx_q + HdrIdxW'(1);
      if (hdr_idx_q == HdrLastIdx) begin
        hdr_active_d = 1'b0;
      end
    end else if (s1_go && (filt_res.kind == KIND_BYTE)) begin
      out_valid_d = 1'b1;
      out_byte_d  = s1_byte_q;
      out_last_d  = filt_res.last;
    end else if (s1_go && (filt_res.kind == KIND_HDR)) begin
      // start the burst: the marker byte is replaced by the header
      out_valid_d  = 1'b1;
      out_byte_d   = hdr_byte;
      out_last_d   = 1'b0;
      hdr_active_d = 1'b1;
      hdr_idx_d    = HdrIdxW'(1);
      hdr_last_d   = filt_res.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hdr_active_q <= 1'b0;
      hdr_idx_q    <= '0;
      hdr_last_q   <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hdr_active_q <= hdr_active_d;
      hdr_idx_q    <= hdr_idx_d;
      hdr_last_q   <= hdr_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: src/ax25f_filter.sv
// Per-frame byte tracking and address filter: position, held length and
// match state. Depends on ax25f_pkg.
`default_nettype none

module ax25f_filter import ax25f_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [7:0]      data_byte_i,
  input  logic            frame_end_i,
  input  logic [LenW-1:0] frame_length_i,
  input  cfg_t            cfg_i,
  output filt_res_t       res_o
);

  logic [LenW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  held_q, held_d;
  logic             dest_ok_q, dest_ok_d;
  logic             src_ok_q, src_ok_d;
  logic             seen_q, seen_d;
  logic             drop_q, drop_d;
  logic [CharW-1:0] fc;
  logic [LenW-1:0]  len_clamped;
  logic [LenW-1:0]  src_off;

  assign fc          = data_byte_i[7:1];
  assign len_clamped = (32'(frame_length_i) > MaxFrameBytes) ? LenW'(MaxFrameBytes)
                                                             : frame_length_i;
  assign src_off     = pos_q - SrcFirstPos;

  always_comb begin
    pos_d     = pos_q;
    held_d    = held_q;
    dest_ok_d = dest_ok_q;
    src_ok_d  = src_ok_q;
    seen_d    = seen_q;
    drop_d    = drop_q;
    if (advance_i) begin
      if (pos_q == '0) begin
        held_d    = len_clamped;
        dest_ok_d = 1'b1;
        src_ok_d  = 1'b1;
        seen_d    = 1'b0;
        drop_d    = 1'b0;
      end
      if (pos_q <= DestLastChar) begin
        if (!char_agrees(cfg_i.dest_callsign, pos_q[2:0], fc, seen_d)) begin
          dest_ok_d = 1'b0;
        end
        if (ends_call(fc)) begin
          seen_d = 1'b1;
        end
      end else if (pos_q == DestSsidPos) begin
        if (fc[SsidW-1:0] != cfg_i.dest_ssid) begin
          dest_ok_d = 1'b0;
        end
        if (cfg_i.filter_mode[0] && !dest_ok_d) begin
          drop_d = 1'b1;
        end
        seen_d = 1'b0;
      end else if (pos_q <= SrcLastChar) begin
        if (!char_agrees(cfg_i.src_callsign, src_off[2:0], fc, seen_d)) begin
          src_ok_d = 1'b0;
        end
        if (ends_call(fc)) begin
          seen_d = 1'b1;
        end
      end else if (pos_q == SrcSsidPos) begin
        if (fc[SsidW-1:0] != cfg_i.src_ssid) begin
          src_ok_d = 1'b0;
        end
        if (cfg_i.filter_mode[1] && !src_ok_d) begin
          drop_d = 1'b1;
        end
        seen_d = 1'b0;
      end
      // frame end restarts the frame; held length stays until the next first byte
      if (frame_end_i) begin
        pos_d     = '0;
        dest_ok_d = 1'b1;
        src_ok_d  = 1'b1;
        seen_d    = 1'b0;
        drop_d    = 1'b0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      held_q    <= '0;
      dest_ok_q <= 1'b1;
      src_ok_q  <= 1'b1;
      seen_q    <= 1'b0;
      drop_q    <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      held_q    <= held_d;
      dest_ok_q <= dest_ok_d;
      src_ok_q  <= src_ok_d;
      seen_q    <= seen_d;
      drop_q    <= drop_d;
    end
  end

  // Output decision uses registered state: drop only changes before data bytes
  always_comb begin
    res_o.kind     = KIND_NONE;
    res_o.last     = frame_end_i || (pos_q == (held_q - LenW'(1)));
    res_o.held_len = held_q;
    if (!drop_q && (held_q >= MinLen) && (pos_q >= FirstDataPos) && (pos_q < held_q)) begin
      if ((pos_q == FirstDataPos) && (data_byte_i == IpMarker)) begin
        res_o.kind = KIND_HDR;
      end else begin
        res_o.kind = KIND_BYTE;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ax25f_hdr.sv
// Rebuilt IPv4/UDP header byte lookup: lengths and header checksum from the
// held frame length. Depends on ax25f_pkg.
`default_nettype none

module ax25f_hdr import ax25f_pkg::*; (
  input  logic [HdrIdxW-1:0] idx_i,
  input  logic [LenW-1:0]    held_len_i,
  output logic [7:0]         byte_o
);

  logic [15:0] total_len;
  logic [15:0] udp_len;
  logic [16:0] cs_sum;
  logic [15:0] cs_fold;
  logic [15:0] cs;

  assign total_len = 16'(held_len_i) + TlOffset;
  assign udp_len   = 16'(held_len_i) - UlOffset;
  assign cs_sum    = 17'(CsBase) + 17'(total_len);
  assign cs_fold   = cs_sum[15:0] + 16'(cs_sum[16]);
  assign cs        = ~cs_fold;

  always_comb begin
    byte_o = 8'h00;
    if (idx_i <= HdrLastIdx) begin
      byte_o = HdrTemplate[idx_i];
    end
    case (idx_i)
      HdrTlHi: byte_o = total_len[15:8];
      HdrTlLo: byte_o = total_len[7:0];
      HdrCsHi: byte_o = cs[15:8];
      HdrCsLo: byte_o = cs[7:0];
      HdrUlHi: byte_o = udp_len[15:8];
      HdrUlLo: byte_o = udp_len[7:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/ax25f_checker.sv
// Port-level checks for ax25_filter_ip_header_rebuild and the bind that
// attaches them. Depends on ax25f_pkg.
`default_nettype none

module ax25f_checker import ax25f_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [7:0]          data_byte_i,
  input logic                frame_end_i,
  input logic [LenW-1:0]     frame_length_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [7:0]          out_byte_o,
  input logic                out_last_o
);

  // A stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("output transaction changed while stalled");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  // With the output side empty no header burst runs, so the input is open
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with output empty");

  // A stalled input transaction stays offered with its payload unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i) &&
      $stable(frame_end_i) && $stable(frame_length_i))
    else $error("input transaction changed while stalled");

  // An offered output transaction carries a known payload
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({out_byte_o, out_last_o}))
    else $error("output payload unknown while valid");

endmodule

bind ax25_filter_ip_header_rebuild ax25f_checker u_ax25f_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for ax25_filter_ip_header_rebuild: drives AX.25 frames byte by byte,
// predicts the filtered, header-rebuilt packet stream and checks every output transaction.
// Depends on ax25f_pkg (widths, config index enum, cfg_t) and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import ax25f_pkg::*;

  localparam int        HALF_PERIOD  = 6;
  localparam int        RESET_CYCLES = 7;
  localparam int        SETTLE       = 8;     // cycles to let the pipeline empty out
  localparam int        HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int        WATCHDOG     = 4000;  // cycles without any transaction
  localparam int        PHASE_BYTES  = 75;
  localparam logic [7:0] IP_MARKER   = 8'h46;
  localparam int        POS_DEST_SSID = 6;
  localparam int        POS_SRC_SSID  = 13;
  localparam int        POS_PAYLOAD   = 16;
  localparam int        HDR_LEN       = 28;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // Predictor of the filter plus the queue of packet bytes it expects.
  class rebuild_scoreboard;
    cfg_t             cfg;
    logic [LenW-1:0]  byte_pos;
    logic [LenW-1:0]  held_len;
    bit               dest_ok;
    bit               src_ok;
    bit               cut_seen;
    bit               dropped;
    pkt_byte_t        expected_q[$];
    int               errors;
    int               bytes_in;
    int               bytes_out;
    int               headers;
    int               dropped_frames;

    function new();
      cfg      = '0;
      held_len = '0;
      restart();
    endfunction

    function void restart();
      byte_pos = '0;
      dest_ok  = 1'b1;
      src_ok   = 1'b1;
      cut_seen = 1'b0;
      dropped  = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_cut(logic [CharW-1:0] c);
      return (c == 7'h20) || (c == 7'h00);
    endfunction

    // Number of characters before the configured callsign ends (6 when it never does).
    function int cut_len(logic [CallW-1:0] call);
      int k;
      k = NumChars;
      for (int i = NumChars - 1; i >= 0; i--) begin
        if (is_cut(call[CallW-1-CharW*i -: CharW])) k = i;
      end
      return k;
    endfunction

    function bit char_ok(logic [CallW-1:0] call, int idx, logic [CharW-1:0] fc);
      bit cfg_done;
      bit frm_done;
      cfg_done = (idx >= cut_len(call));
      frm_done = cut_seen || is_cut(fc);
      if (cfg_done || frm_done) return cfg_done && frm_done;
      return fc == call[CallW-1-CharW*idx -: CharW];
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_FILTER_MODE: cfg.filter_mode   = d[ModeW-1:0];
        CFG_DEST_CALL:   cfg.dest_callsign = d[CallW-1:0];
        CFG_DEST_SSID:   cfg.dest_ssid     = d[SsidW-1:0];
        CFG_SRC_CALL:    cfg.src_callsign  = d[CallW-1:0];
        CFG_SRC_SSID:    cfg.src_ssid      = d[SsidW-1:0];
        default: ;
      endcase
    endfunction

    function void mark_drop();
      if (!dropped) dropped_frames++;
      dropped = 1'b1;
    endfunction

    function void push_byte(logic [7:0] d, logic l);
      pkt_byte_t e;
      e.data = d;
      e.last = l;
      expected_q.push_back(e);
    endfunction

    // IPv4/UDP header from the held frame length; checksum over the first 20 bytes.
    function void push_header(logic l);
      logic [7:0]  hdr [HDR_LEN];
      logic [15:0] tl;
      logic [15:0] ul;
      int unsigned acc;
      hdr = '{8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00,
              8'h40, 8'h11, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01,
              8'h01, 8'h01, 8'h01, 8'h02, 8'h8b, 8'hc1, 8'h8b, 8'hc1,
              8'h00, 8'h00, 8'h00, 8'h00};
      tl = 16'(held_len) + 16'd11;
      ul = 16'(held_len) - 16'd17;
      {hdr[2], hdr[3]}   = tl;
      {hdr[24], hdr[25]} = ul;
      acc = 32'hffff;
      for (int i = 0; i < 20; i += 2) begin
        acc += {hdr[i], hdr[i+1]};
        if (acc > 32'hffff) acc -= 32'hffff;
      end
      {hdr[10], hdr[11]} = ~acc[15:0];
      for (int i = 0; i < HDR_LEN; i++) push_byte(hdr[i], (i == HDR_LEN - 1) ? l : 1'b0);
      headers++;
    endfunction

    function void note_input(logic [7:0] b, logic fend, logic [LenW-1:0] flen);
      logic [LenW-1:0]  p;
      logic [CharW-1:0] fc;
      logic             lst;
      p  = byte_pos;
      fc = b[7:1];
      bytes_in++;
      if (p == 0) begin
        restart();
        held_len = flen;
      end
      if (p < POS_DEST_SSID) begin
        if (!char_ok(cfg.dest_callsign, int'(p), fc)) dest_ok = 1'b0;
        if (is_cut(fc)) cut_seen = 1'b1;
      end else if (p == POS_DEST_SSID) begin
        if (fc[3:0] != cfg.dest_ssid) dest_ok = 1'b0;
        if (cfg.filter_mode[0] && !dest_ok) mark_drop();
        cut_seen = 1'b0;
      end else if (p < POS_SRC_SSID) begin
        if (!char_ok(cfg.src_callsign, int'(p) - 7, fc)) src_ok = 1'b0;
        if (is_cut(fc)) cut_seen = 1'b1;
      end else if (p == POS_SRC_SSID) begin
        if (fc[3:0] != cfg.src_ssid) src_ok = 1'b0;
        if (cfg.filter_mode[1] && !src_ok) mark_drop();
        cut_seen = 1'b0;
      end
      if (!dropped && held_len >= 17 && p >= POS_PAYLOAD && p < held_len) begin
        lst = fend || (p == held_len - 1'b1);
        if (p == POS_PAYLOAD && b == IP_MARKER) push_header(lst);
        else push_byte(b, lst);
      end
      if (fend) restart();
      else if (p != '1) byte_pos = p + 1'b1;
    endfunction

    function void check_output(logic [7:0] b, logic l);
      pkt_byte_t e;
      if (expected_q.size() == 0) begin
        $error("out_byte: no byte expected, got %h (out_last %b)", b, l);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      bytes_out++;
      if (b !== e.data) begin
        $error("out_byte: expected %h, got %h", e.data, b);
        errors++;
      end
      if (l !== e.last) begin
        $error("out_last: expected %b, got %b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                frame_end_i;
  logic [LenW-1:0]     frame_length_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          out_byte_o;
  logic                out_last_o;

  rebuild_scoreboard sb;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  int idle_cycles;
  int frames_sent;
  int bytes_sent;

  // Current register values, used to build frames that pass the filter.
  logic [CallW-1:0] cur_dest_call;
  logic [SsidW-1:0] cur_dest_ssid;
  logic [CallW-1:0] cur_src_call;
  logic [SsidW-1:0] cur_src_ssid;

  ax25_filter_ip_header_rebuild dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .frame_end_i    (frame_end_i),
    .frame_length_i (frame_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Sample every handshake at the rising edge; all inputs move on the falling edge,
  // so the values seen here are the ones the block registers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_input(data_byte_i, frame_end_i, frame_length_i);
      if (out_valid_o && out_ready_i) sb.check_output(out_byte_o, out_last_o);
    end
    // Watchdog: any transaction counts as progress.
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked so the
  // block fills up and pushes back on its input.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte; idle first at random, then hold valid until accepted.
  task automatic send_byte(input logic [7:0] b, input logic fend, input logic [LenW-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    frame_end_i    <= fend;
    frame_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected byte is out, then let bytes that
  // retire without output settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [ModeW-1:0] mode,
                           input logic [CallW-1:0] dcall, input logic [SsidW-1:0] dssid,
                           input logic [CallW-1:0] scall, input logic [SsidW-1:0] sssid);
    write_reg(CFG_FILTER_MODE, CfgDataW'(mode));
    write_reg(CFG_DEST_CALL, dcall);
    write_reg(CFG_DEST_SSID, CfgDataW'(dssid));
    write_reg(CFG_SRC_CALL, scall);
    write_reg(CFG_SRC_SSID, CfgDataW'(sssid));
    cur_dest_call = dcall;
    cur_dest_ssid = dssid;
    cur_src_call  = scall;
    cur_src_ssid  = sssid;
  endtask

  // Callsign of printable characters, cut by a space or NUL at a random place
  // (or not at all), random junk after the cut.
  function automatic logic [CallW-1:0] random_call();
    logic [CallW-1:0] call;
    int               k;
    k = $urandom_range(NumChars);
    for (int i = 0; i < NumChars; i++) begin
      if (i < k) call[CallW-1-CharW*i -: CharW] = CharW'($urandom_range(48, 90));
      else if (i == k) call[CallW-1-CharW*i -: CharW] = $urandom_range(1) ? 7'h20 : 7'h00;
      else call[CallW-1-CharW*i -: CharW] = CharW'($urandom_range(127));
    end
    return call;
  endfunction

  // Append six callsign bytes and the SSID byte; when ok is clear, corrupt one of them.
  task automatic add_call(ref logic [7:0] fb[$], input logic [CallW-1:0] call,
                          input logic [SsidW-1:0] ssid, input bit ok);
    logic [CharW-1:0] cs [NumChars];
    logic [SsidW-1:0] s;
    int               k;
    int               which;
    k = sb.cut_len(call);
    s = ssid;
    for (int i = 0; i < NumChars; i++) begin
      if (i < k) cs[i] = call[CallW-1-CharW*i -: CharW];
      else if (i == k) cs[i] = $urandom_range(1) ? 7'h20 : 7'h00;
      else cs[i] = CharW'($urandom_range(127));
    end
    if (!ok) begin
      which = $urandom_range(NumChars);
      if (which < NumChars) cs[which] ^= CharW'($urandom_range(1, 127));
      else s ^= SsidW'($urandom_range(1, 15));
    end
    for (int i = 0; i < NumChars; i++) fb.push_back({cs[i], 1'($urandom_range(1))});
    fb.push_back({3'($urandom_range(7)), s, 1'($urandom_range(1))});
  endtask

  // Build and send one frame of n bytes; only byte 0 carries the real length.
  task automatic send_frame(input int n, input int flen, input bit marker,
                            input bit d_ok, input bit s_ok, input bit noise);
    logic [7:0] fb [$];
    int         i;
    if (noise) begin
      for (i = 0; i < n; i++) fb.push_back(8'($urandom_range(255)));
    end else begin
      add_call(fb, cur_dest_call, cur_dest_ssid, d_ok);
      add_call(fb, cur_src_call, cur_src_ssid, s_ok);
      fb.push_back(8'($urandom_range(255)));
      fb.push_back(8'($urandom_range(255)));
      fb.push_back(marker ? IP_MARKER : 8'($urandom_range(255)));
      while (fb.size() < n) fb.push_back(8'($urandom_range(255)));
    end
    for (i = 0; i < n; i++) begin
      send_byte(fb[i], i == n - 1, (i == 0) ? LenW'(flen) : LenW'($urandom_range(2047)));
    end
    frames_sent++;
    bytes_sent += n;
  endtask

  // Mostly well-formed frames that pass the filter; the rest are short, truncated,
  // padded, corrupted or pure noise.
  task automatic random_frame();
    int r;
    int n;
    int flen;
    bit noise;
    r     = $urandom_range(99);
    noise = 1'b0;
    if (r < 55) begin
      flen = $urandom_range(17, 36);
      n    = flen;
    end else if (r < 65) begin
      // filler bytes past the length
      flen = $urandom_range(17, 36);
      n    = flen + $urandom_range(1, 4);
    end else if (r < 75) begin
      // early end against a long declared length
      flen = $urandom_range(17, 2047);
      n    = $urandom_range(1, 40);
      if (n > flen) n = flen;
    end else if (r < 85) begin
      // declared length too short for any output
      flen = $urandom_range(0, 16);
      n    = $urandom_range(1, 24);
    end else if (r < 90) begin
      // frame ends before the payload starts
      flen = $urandom_range(17, 30);
      n    = $urandom_range(1, 16);
    end else begin
      noise = 1'b1;
      flen  = $urandom_range(0, 40);
      n     = $urandom_range(1, 40);
    end
    send_frame(n, flen, $urandom_range(1), $urandom_range(9) != 0,
               $urandom_range(9) != 0, noise);
  endtask

  task automatic run_phase(input int target, input bit hold, input bit pause);
    int  start;
    bit  paused;
    start  = bytes_sent;
    paused = 1'b0;
    if (hold) hold_off_req = 1'b1;
    while (bytes_sent - start < target) begin
      random_frame();
      // Pause the sender mid-phase until the output side has caught up.
      if (pause && !paused && (bytes_sent - start >= target / 2)) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
  endtask

  initial begin
    sb             = new();
    idle_cycles    = 0;
    frames_sent    = 0;
    bytes_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    cur_dest_call  = '0;
    cur_dest_ssid  = '0;
    cur_src_call   = '0;
    cur_src_ssid   = '0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_FILTER_MODE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    frame_end_i    = 1'b0;
    frame_length_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset config (no filter). Minimum-length frame with the marker
    // (header ends the packet), marker frame ending early against the longest
    // length, and a three-byte frame that yields nothing.
    send_frame(17, 17, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(17, 2047, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(3, 0, 1'b0, 1'b1, 1'b1, 1'b0);
    drain();

    // Destination filter only; source register all ones, SSID extremes.
    configure(2'd1, random_call(), 4'hf, '1, 4'h0);
    run_phase(PHASE_BYTES, 1'b0, 1'b0);

    // Source filter only; sender idles often.
    send_idle_pct = 47;
    configure(2'd2, '1, 4'h0, random_call(), SsidW'($urandom_range(15)));
    run_phase(PHASE_BYTES, 1'b0, 1'b0);

    // Both filters, empty destination callsign; receiver stalls and holds off.
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    configure(2'd3, '0, 4'h0, random_call(), 4'hf);
    run_phase(PHASE_BYTES, 1'b1, 1'b0);

    // Both filters, random registers; light idling on both sides, one full pause.
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    configure(2'd3, random_call(), SsidW'($urandom_range(15)), random_call(),
              SsidW'($urandom_range(15)));
    run_phase(PHASE_BYTES, 1'b0, 1'b1);

    $display("Ran %0d frames (%0d bytes in) over all four filter modes and idle patterns,",
             frames_sent, sb.bytes_in);
    $display("checked %0d output bytes, %0d rebuilt headers, %0d frames filtered out.",
             sb.bytes_out, sb.headers, sb.dropped_frames);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ax25f_pkg.sv
src/ax25f_filter.sv
src/ax25f_hdr.sv
src/ax25_filter_ip_header_rebuild.sv
src/ax25f_checker.sv
sim/testbench.sv
